// ----- hw/rtl/wod_pkg.sv -----
package wod_pkg;

   localparam int WHEEL_COUNT = 4;
   localparam int WHEEL_FL = 0;
   localparam int WHEEL_FR = 1;
   localparam int WHEEL_BL = 2;
   localparam int WHEEL_BR = 3;

   localparam int IN_COUNT_WIDTH = 31;
   localparam int THRESH_WIDTH = 31;
   localparam int SCALE_WIDTH = 32;
   localparam int DIST_WIDTH = 32;
   localparam int MAG_WIDTH = 31;
   localparam int FRAC_SHIFT = 8;
   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE_FRONT_LEFT = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE_FRONT_RIGHT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE_BACK_LEFT = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCALE_BACK_RIGHT = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WRAP_THRESHOLD = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPIKE_LIMIT = 3'd5;

   localparam logic [THRESH_WIDTH-1:0] WRAP_THRESHOLD_RESET = 31'd10000;
   localparam logic [THRESH_WIDTH-1:0] SPIKE_LIMIT_RESET = 31'd1000;

   typedef struct packed {
      logic [IN_COUNT_WIDTH-1:0] count_front_left;
      logic [IN_COUNT_WIDTH-1:0] count_front_right;
      logic [IN_COUNT_WIDTH-1:0] count_back_left;
      logic [IN_COUNT_WIDTH-1:0] count_back_right;
      logic                      left_new;
      logic                      right_new;
      logic                      turn_flag;
      logic                      stop_flag;
   } req_item_type;

   typedef struct packed {
      logic signed [DIST_WIDTH-1:0] travel_delta;
      logic signed [DIST_WIDTH-1:0] dist_front_left;
      logic signed [DIST_WIDTH-1:0] dist_front_right;
      logic signed [DIST_WIDTH-1:0] dist_back_left;
      logic signed [DIST_WIDTH-1:0] dist_back_right;
   } rsp_item_type;

   typedef struct packed {
      logic [THRESH_WIDTH-1:0] wrap_threshold;
      logic [THRESH_WIDTH-1:0] spike_limit;
   } thresh_cfg_type;

   typedef logic [WHEEL_COUNT-1:0][SCALE_WIDTH-1:0] scale_set_type;

   typedef struct packed {
      logic [MAG_WIDTH-1:0] mag;
      logic                 neg;
   } wheel_diff_type;

   typedef struct packed {
      wheel_diff_type [WHEEL_COUNT-1:0] wheel;
      logic                             hold;
   } diff_item_type;

endpackage

// ----- hw/rtl/wod_req_if.sv -----
interface wod_req_if;
   logic                  valid;
   logic                  ready;
   wod_pkg::req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/wod_rsp_if.sv -----
interface wod_rsp_if;
   logic                  valid;
   logic                  ready;
   wod_pkg::rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/wod_front.sv -----
module wod_front #(
   parameter int COUNT_WIDTH = 31
) (
   input  logic                    clock,
   input  logic                    reset,
   wod_req_if.sink                 req_bus,
   input  wod_pkg::thresh_cfg_type thresh,
   input  logic                    queue_full,
   output logic                    push,
   output wod_pkg::diff_item_type  push_data
);
   import wod_pkg::*;

   localparam int DIFF_WIDTH = COUNT_WIDTH + 2;
   localparam int CMP_WIDTH = (DIFF_WIDTH > THRESH_WIDTH) ? DIFF_WIDTH : THRESH_WIDTH;
   localparam logic signed [DIFF_WIDTH-1:0] SPAN = {2'b01, {COUNT_WIDTH{1'b0}}};
   localparam logic [COUNT_WIDTH-1:0] HALF_SPAN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   logic                   accept;
   logic [COUNT_WIDTH-1:0] cur [WHEEL_COUNT];
   logic [COUNT_WIDTH-1:0] prev_ff [WHEEL_COUNT];
   logic [COUNT_WIDTH-1:0] prev_in [WHEEL_COUNT];
   logic [MAG_WIDTH-1:0]   wheel_mag [WHEEL_COUNT];
   logic                   wheel_neg [WHEEL_COUNT];

   assign req_bus.ready = !queue_full;
   assign accept = req_bus.valid && !queue_full;
   assign push = accept;

   assign cur[WHEEL_FL] = COUNT_WIDTH'(req_bus.data.count_front_left);
   assign cur[WHEEL_FR] = COUNT_WIDTH'(req_bus.data.count_front_right);
   assign cur[WHEEL_BL] = COUNT_WIDTH'(req_bus.data.count_back_left);
   assign cur[WHEEL_BR] = COUNT_WIDTH'(req_bus.data.count_back_right);

   for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_wheel
      logic signed [DIFF_WIDTH-1:0] cur_x;
      logic signed [DIFF_WIDTH-1:0] prev_x;
      logic signed [DIFF_WIDTH-1:0] d_direct;
      logic signed [DIFF_WIDTH-1:0] d_wrap;
      logic [DIFF_WIDTH-1:0]        mag_direct;
      logic [DIFF_WIDTH-1:0]        mag_wrap;
      logic [DIFF_WIDTH-1:0]        mag_sel;
      logic                         wrapped;
      logic                         spike_hit;
      logic                         neg_sel;
      logic                         side_new;

      assign side_new = (w == WHEEL_FL || w == WHEEL_BL) ? req_bus.data.left_new
                                                         : req_bus.data.right_new;
      assign cur_x = $signed({2'b00, cur[w]});
      assign prev_x = $signed({2'b00, prev_ff[w]});
      assign d_direct = cur_x - prev_x;
      // recompute across the counter wrap, direction picked by the old count
      assign d_wrap = (prev_ff[w] > HALF_SPAN) ? cur_x - prev_x + SPAN
                                               : cur_x - prev_x - SPAN;
      assign mag_direct = d_direct[DIFF_WIDTH-1] ? -d_direct : d_direct;
      assign mag_wrap = d_wrap[DIFF_WIDTH-1] ? -d_wrap : d_wrap;
      assign wrapped = CMP_WIDTH'(mag_direct) > CMP_WIDTH'(thresh.wrap_threshold);
      assign spike_hit = CMP_WIDTH'(mag_wrap) > CMP_WIDTH'(thresh.spike_limit);

      always_comb begin
         if (!wrapped) begin
            mag_sel = mag_direct;
            neg_sel = d_direct[DIFF_WIDTH-1];
         end else if (spike_hit) begin
            mag_sel = '0;
            neg_sel = 1'b0;
         end else begin
            mag_sel = mag_wrap;
            neg_sel = d_wrap[DIFF_WIDTH-1];
         end
      end

      // magnitude never exceeds the threshold width once filtered
      assign wheel_mag[w] = side_new ? MAG_WIDTH'(mag_sel) : '0;
      assign wheel_neg[w] = side_new && neg_sel;
      assign prev_in[w] = (accept && side_new) ? cur[w] : prev_ff[w];

      always_ff @(posedge clock) begin
         if (reset) begin
            prev_ff[w] <= '0;
         end else begin
            prev_ff[w] <= prev_in[w];
         end
      end
   end

   always_comb begin
      push_data.hold = req_bus.data.turn_flag || req_bus.data.stop_flag;
      for (int w = 0; w < WHEEL_COUNT; w++) begin
         push_data.wheel[w].mag = wheel_mag[w];
         push_data.wheel[w].neg = wheel_neg[w];
      end
   end

   a_left_prev_kept: assert property (@(posedge clock) disable iff (reset)
      accept && !req_bus.data.left_new |=> $stable(prev_ff[WHEEL_FL]) && $stable(prev_ff[WHEEL_BL]))
      else $error("left side counts changed without a fresh sample");

endmodule

// ----- hw/rtl/wod_queue.sv -----
module wod_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wod_pkg::diff_item_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   pop_valid,
   output wod_pkg::diff_item_type pop_data
);
   import wod_pkg::*;

   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH = PTR_WIDTH + 1;
   localparam logic [CNT_WIDTH-1:0] COUNT_MAX = CNT_WIDTH'(QUEUE_DEPTH);

   diff_item_type        entries_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;

   assign full = (count_ff == COUNT_MAX);
   assign pop_valid = (count_ff != '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("queue fill count beyond depth");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill count missed a push");

endmodule

// ----- hw/rtl/wod_back.sv -----
module wod_back (
   input  logic                   clock,
   input  logic                   reset,
   input  wod_pkg::scale_set_type scale,
   input  logic                   pop_valid,
   input  wod_pkg::diff_item_type pop_data,
   output logic                   pop,
   wod_rsp_if.source              rsp_bus
);
   import wod_pkg::*;

   localparam int PROD_WIDTH = MAG_WIDTH + SCALE_WIDTH;
   localparam int SHIFTED_WIDTH = PROD_WIDTH - FRAC_SHIFT;
   localparam logic [SHIFTED_WIDTH-1:0] POS_LIMIT = SHIFTED_WIDTH'(33'h0_7FFF_FFFF);
   localparam logic [SHIFTED_WIDTH-1:0] NEG_LIMIT = SHIFTED_WIDTH'(33'h0_8000_0000);
   localparam logic signed [DIST_WIDTH-1:0] DIST_MIN = {1'b1, {(DIST_WIDTH-1){1'b0}}};
   localparam logic signed [DIST_WIDTH-1:0] DIST_MAX = {1'b0, {(DIST_WIDTH-1){1'b1}}};

   typedef struct packed {
      logic [WHEEL_COUNT-1:0][PROD_WIDTH-1:0] prod;
      logic [WHEEL_COUNT-1:0]                 neg;
      logic                                   hold;
   } prod_stage_type;

   typedef struct packed {
      logic [WHEEL_COUNT-1:0][DIST_WIDTH-1:0] wheel_dist;
      logic                                   hold;
   } dist_stage_type;

   function automatic logic [DIST_WIDTH-1:0] dist_mag(input logic [DIST_WIDTH-1:0] v);
      return v[DIST_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [DIST_WIDTH-1:0] pick_min(input logic [DIST_WIDTH-1:0] a,
                                                     input logic [DIST_WIDTH-1:0] b);
      return (dist_mag(a) < dist_mag(b) || b == '0) ? a : b;
   endfunction

   logic           stage_en;
   logic           s1_valid_ff, s1_valid_in;
   prod_stage_type s1_ff, s1_in;
   logic           s2_valid_ff, s2_valid_in;
   dist_stage_type s2_ff, s2_in;
   logic           out_valid_ff, out_valid_in;
   rsp_item_type   out_ff, out_in;

   logic [DIST_WIDTH-1:0] min_front;
   logic [DIST_WIDTH-1:0] min_back;
   logic [DIST_WIDTH-1:0] min_all;

   // the whole pipe advances together; stall only while a result waits
   assign stage_en = !out_valid_ff || rsp_bus.ready;
   assign pop = stage_en && pop_valid;

   always_comb begin
      s1_valid_in = pop_valid;
      s1_in.hold = pop_data.hold;
      for (int w = 0; w < WHEEL_COUNT; w++) begin
         s1_in.neg[w] = pop_data.wheel[w].neg;
         s1_in.prod[w] = {{SCALE_WIDTH{1'b0}}, pop_data.wheel[w].mag}
                       * {{MAG_WIDTH{1'b0}}, scale[w]};
      end
   end

   always_comb begin
      logic [SHIFTED_WIDTH-1:0] shifted;
      logic [SHIFTED_WIDTH-1:0] lim;
      logic [DIST_WIDTH-1:0]    clipped;
      s2_valid_in = s1_valid_ff;
      s2_in.hold = s1_ff.hold;
      for (int w = 0; w < WHEEL_COUNT; w++) begin
         shifted = s1_ff.prod[w][PROD_WIDTH-1:FRAC_SHIFT];
         lim = s1_ff.neg[w] ? NEG_LIMIT : POS_LIMIT;
         clipped = (shifted > lim) ? DIST_WIDTH'(lim) : DIST_WIDTH'(shifted);
         s2_in.wheel_dist[w] = s1_ff.neg[w] ? ('0 - clipped) : clipped;
      end
   end

   assign min_front = pick_min(s2_ff.wheel_dist[WHEEL_FL], s2_ff.wheel_dist[WHEEL_FR]);
   assign min_back = pick_min(s2_ff.wheel_dist[WHEEL_BL], s2_ff.wheel_dist[WHEEL_BR]);
   assign min_all = pick_min(min_back, min_front);

   always_comb begin
      out_valid_in = s2_valid_ff;
      out_in.dist_front_left = s2_ff.wheel_dist[WHEEL_FL];
      out_in.dist_front_right = s2_ff.wheel_dist[WHEEL_FR];
      out_in.dist_back_left = s2_ff.wheel_dist[WHEEL_BL];
      out_in.dist_back_right = s2_ff.wheel_dist[WHEEL_BR];
      priority if (s2_ff.hold) begin
         out_in.travel_delta = '0;
      end else if (min_all == DIST_MIN) begin
         out_in.travel_delta = DIST_MAX;
      end else begin
         out_in.travel_delta = '0 - min_all;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (stage_en) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data = out_ff;

   a_pipe_holds: assert property (@(posedge clock) disable iff (reset)
      !stage_en |=> $stable(s1_valid_ff) && $stable(s2_valid_ff) && $stable(s2_ff))
      else $error("pipeline moved while the output stalled");

endmodule

// ----- hw/rtl/wheel_odometry_delta.sv -----
// Four-wheel odometry step. Each item carries four raw encoder counts and
// side/turn/stop flags; each gives one result with the four saturated Q16.16
// wheel distances and the negated least-magnitude distance (a zero skipped
// only as second operand; zero while turning or stopped). One item per clock
// is sustained while results are taken; the rate is set by the four 31x32
// multipliers that work in parallel in the first back-end stage. An item is
// differenced against the stored counts as it is accepted, waits in a
// four-entry queue, and crosses a three-stage back end (multiply, saturate,
// select). The user must write scale and threshold registers via the csr port
// only while idle; the block does not enforce it. Unknown indexes are ignored.
module wheel_odometry_delta #(
   parameter int COUNT_WIDTH = 31
) (
   input  logic                                 clock,
   input  logic                                 reset,
   wod_req_if.sink                              req_bus,
   wod_rsp_if.source                            rsp_bus,
   input  logic                                 csr_we,
   input  logic [wod_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [wod_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import wod_pkg::*;

   scale_set_type  scale_ff, scale_in;
   thresh_cfg_type thresh_ff, thresh_in;

   logic          queue_full;
   logic          push;
   diff_item_type push_data;
   logic          pop;
   logic          pop_valid;
   diff_item_type pop_data;

   always_comb begin
      scale_in = scale_ff;
      thresh_in = thresh_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SCALE_FRONT_LEFT:  scale_in[WHEEL_FL] = SCALE_WIDTH'(csr_wdata);
            CSR_SCALE_FRONT_RIGHT: scale_in[WHEEL_FR] = SCALE_WIDTH'(csr_wdata);
            CSR_SCALE_BACK_LEFT:   scale_in[WHEEL_BL] = SCALE_WIDTH'(csr_wdata);
            CSR_SCALE_BACK_RIGHT:  scale_in[WHEEL_BR] = SCALE_WIDTH'(csr_wdata);
            CSR_WRAP_THRESHOLD:    thresh_in.wrap_threshold = THRESH_WIDTH'(csr_wdata);
            CSR_SPIKE_LIMIT:       thresh_in.spike_limit = THRESH_WIDTH'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
         thresh_ff.wrap_threshold <= WRAP_THRESHOLD_RESET;
         thresh_ff.spike_limit <= SPIKE_LIMIT_RESET;
      end else begin
         scale_ff <= scale_in;
         thresh_ff <= thresh_in;
      end
   end

   wod_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .thresh     (thresh_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   wod_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   wod_back u_back (
      .clock     (clock),
      .reset     (reset),
      .scale     (scale_ff),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule
